// File: hw/rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants of the sorted array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

    // built number of cells in the chain
    localparam int DEPTH = 64;

    // fixed field widths
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // depth as a count value
    localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(DEPTH);

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_NOP  = 2'd3
    } t_req_type;

    // status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // what every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_RSVD   = 2'd3
    } t_cell_op;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic signed [KEY_W-1:0] key;
    } t_cell_nbr;

endpackage

// File: hw/rtl/sapq_req_if.sv
// ----------------------------------------------------------------------------
// sapq_req_if
// Request channel: operation code and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapq_req_if;
    logic                             valid;
    logic                             ready;
    logic [sapq_pkg::REQ_W-1:0]       req_type;
    logic signed [sapq_pkg::KEY_W-1:0] key_in;

    modport source (output valid, output req_type, output key_in, input ready);
    modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

// File: hw/rtl/sapq_rsp_if.sv
// ----------------------------------------------------------------------------
// sapq_rsp_if
// Result channel: status, key and count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sapq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sapq_pkg::STAT_W-1:0]       status;
    logic signed [sapq_pkg::KEY_W-1:0] key_out;
    logic [sapq_pkg::COUNT_W-1:0]      count;

    modport source (output valid, output status, output key_out, output count,
                    input ready);
    modport sink   (input valid, input status, input key_out, input count,
                    output ready);
endinterface

// File: hw/rtl/sapq_cfg_if.sv
// ----------------------------------------------------------------------------
// sapq_cfg_if
// Configuration write channel carrying the capacity register value.
// ----------------------------------------------------------------------------
interface sapq_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sapq_pkg::CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain. Holds a key and a valid bit, compares its
// key with the incoming key and loads it or a neighbor on insert or pop.
// ----------------------------------------------------------------------------
module sapq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sapq_pkg::t_cell_op                i_op,
    input  logic signed [sapq_pkg::KEY_W-1:0] i_key,
    input  sapq_pkg::t_cell_nbr               i_left,
    input  sapq_pkg::t_cell_nbr               i_right,
    output sapq_pkg::t_cell_nbr               o_state
);

    logic                              r_valid;
    logic                              n_valid;
    logic signed [sapq_pkg::KEY_W-1:0] r_key;
    logic signed [sapq_pkg::KEY_W-1:0] n_key;
    logic                              w_gt;

    // this cell stays in front of the incoming key
    assign w_gt = r_valid && (r_key > i_key);

    // next contents of the slot
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        unique case (i_op)
            sapq_pkg::CELL_INSERT: begin
                if (w_gt) begin
                    n_valid = r_valid;
                    n_key   = r_key;
                end else if (i_left.gt) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                end else begin
                    n_valid = i_left.valid;
                    n_key   = i_left.key;
                end
            end
            sapq_pkg::CELL_POP: begin
                n_valid = i_right.valid;
                n_key   = i_right.key;
            end
            default: begin
                n_valid = r_valid;
                n_key   = r_key;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_state = '{valid: r_valid, gt: w_gt, key: r_key};

endmodule

// File: hw/rtl/sorted_array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Max-first bounded priority queue built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// One request word is taken per clock: every cell compares its key with the
// incoming key in parallel and the chain shifts by one place in the same
// cycle, so an enqueue, dequeue or peek completes as it is taken and its result
// word appears on the output register on the next cycle. A new request is
// taken while the previous result waits, as long as the output register is
// free or being emptied; a stalled result stalls requests. The largest key
// is always in the first cell, equal keys leave newest first. Capacity is
// written over the configuration channel, is not saturated but is checked
// together with the built depth for full, and resets to 64.
module sorted_array_priority_queue_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sapq_req_if.sink   i_req,
    sapq_cfg_if.sink   i_cfg,
    sapq_rsp_if.source o_rsp
);

    localparam int DEPTH = sapq_pkg::DEPTH;

    logic [sapq_pkg::COUNT_W-1:0]      r_count;
    logic [sapq_pkg::COUNT_W-1:0]      n_count;
    logic [sapq_pkg::CAP_W-1:0]        r_cap;
    logic                              r_out_valid;
    logic [sapq_pkg::STAT_W-1:0]       r_out_status;
    logic signed [sapq_pkg::KEY_W-1:0] r_out_key;
    logic [sapq_pkg::COUNT_W-1:0]      r_out_count;

    sapq_pkg::t_status                 w_status;
    logic signed [sapq_pkg::KEY_W-1:0] w_key_out;
    sapq_pkg::t_cell_op                w_op;
    sapq_pkg::t_req_type               w_req;
    logic                              w_take;
    logic                              w_full;
    logic                              w_empty;

    sapq_pkg::t_cell_nbr w_cell [DEPTH];
    sapq_pkg::t_cell_nbr w_left [DEPTH];
    sapq_pkg::t_cell_nbr w_right [DEPTH];

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_take      = i_req.valid && i_req.ready;
    assign w_req       = sapq_pkg::t_req_type'(i_req.req_type);

    // limit checks
    assign w_full  = (r_count >= r_cap) || (r_count >= sapq_pkg::DEPTH_COUNT);
    assign w_empty = (r_count == '0);

    // decode request into chain operation and result word
    always_comb begin
        w_op      = sapq_pkg::CELL_HOLD;
        w_status  = sapq_pkg::ST_DONE;
        w_key_out = '0;
        n_count   = r_count;
        unique case (w_req)
            sapq_pkg::REQ_ENQ: begin
                if (w_full) begin
                    w_status = sapq_pkg::ST_FULL;
                end else begin
                    w_op    = sapq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            sapq_pkg::REQ_DEQ: begin
                if (w_empty) begin
                    w_status = sapq_pkg::ST_EMPTY;
                end else begin
                    w_op      = sapq_pkg::CELL_POP;
                    w_key_out = w_cell[0].key;
                    n_count   = r_count - 1'b1;
                end
            end
            sapq_pkg::REQ_PEEK: begin
                if (w_empty) begin
                    w_status = sapq_pkg::ST_EMPTY;
                end else begin
                    w_key_out = w_cell[0].key;
                end
            end
            default: begin
                w_op = sapq_pkg::CELL_HOLD;
            end
        endcase
        if (!w_take) begin
            w_op    = sapq_pkg::CELL_HOLD;
            n_count = r_count;
        end
    end

    // chain of cells, head holds the largest key
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '{valid: 1'b1, gt: 1'b1, key: '0};
        end else begin : g_mid
            assign w_left[g] = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right[g] = '{valid: 1'b0, gt: 1'b0, key: '0};
        end else begin : g_body
            assign w_right[g] = w_cell[g+1];
        end

        sapq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_key   (i_req.key_in),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_state (w_cell[g])
        );
    end

    // count and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= sapq_pkg::CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_status <= w_status;
            r_out_key    <= w_key_out;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.key_out = r_out_key;
    assign o_rsp.count   = r_out_count;

endmodule
